// ----- hdl/kst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_pkg
// shared types, constants and the set-1 translation tables
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int unsigned FIFO_DEPTH_DEFAULT = 32;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned LEVEL_W     = 6;

  // operation codes carried in s_axis_tuser
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  // scan codes with special meaning
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_CTRL_MAKE    = 8'h1D;
  localparam logic [7:0] SC_CTRL_BREAK   = 8'h9D;
  localparam logic [7:0] SC_ALT_MAKE     = 8'h38;
  localparam logic [7:0] SC_ALT_BREAK    = 8'hB8;
  localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
  localparam logic [7:0] SC_NUM_MAKE     = 8'h45;
  localparam logic [7:0] SC_EXTENDED     = 8'hE0;
  localparam logic [7:0] SC_CAPS_BREAK   = 8'hBA;
  localparam logic [7:0] SC_NUM_BREAK    = 8'hC5;
  localparam logic [7:0] SC_C_MAKE       = 8'h2E;
  localparam logic [6:0] SC_KP_STAR      = 7'd72;

  localparam logic [7:0] CH_NONE    = 8'h00;
  localparam logic [7:0] CH_NP      = 8'h80;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_READ
  } kst_state_e;

  typedef struct packed {
    logic scan;        // process a scan code transaction
    logic pop;         // pop one store entry, read data registered
    logic load_empty;  // load an empty-read result
    logic load_read;   // load the translated popped entry
  } kst_cmd_t;

  typedef struct packed {
    logic empty;
  } kst_status_t;

  function automatic logic [7:0] plain_char(input logic [6:0] code);
    logic [7:0] ch;
    case (code)
      7'd0:  ch = 8'h00;  7'd1:  ch = 8'h1B;  7'd2:  ch = 8'h31;  7'd3:  ch = 8'h32;
      7'd4:  ch = 8'h33;  7'd5:  ch = 8'h34;  7'd6:  ch = 8'h35;  7'd7:  ch = 8'h36;
      7'd8:  ch = 8'h37;  7'd9:  ch = 8'h38;  7'd10: ch = 8'h39;  7'd11: ch = 8'h30;
      7'd12: ch = 8'h2D;  7'd13: ch = 8'h3D;  7'd14: ch = 8'h08;  7'd15: ch = 8'h09;
      7'd16: ch = 8'h71;  7'd17: ch = 8'h77;  7'd18: ch = 8'h65;  7'd19: ch = 8'h72;
      7'd20: ch = 8'h74;  7'd21: ch = 8'h79;  7'd22: ch = 8'h75;  7'd23: ch = 8'h69;
      7'd24: ch = 8'h6F;  7'd25: ch = 8'h70;  7'd26: ch = 8'h5B;  7'd27: ch = 8'h5D;
      7'd28: ch = 8'h0D;
      7'd30: ch = 8'h61;  7'd31: ch = 8'h73;  7'd32: ch = 8'h64;  7'd33: ch = 8'h66;
      7'd34: ch = 8'h67;  7'd35: ch = 8'h68;  7'd36: ch = 8'h6A;  7'd37: ch = 8'h6B;
      7'd38: ch = 8'h6C;  7'd39: ch = 8'h3B;  7'd40: ch = 8'h27;  7'd41: ch = 8'h60;
      7'd43: ch = 8'h5C;  7'd44: ch = 8'h7A;  7'd45: ch = 8'h78;  7'd46: ch = 8'h63;
      7'd47: ch = 8'h76;  7'd48: ch = 8'h62;  7'd49: ch = 8'h6E;  7'd50: ch = 8'h6D;
      7'd51: ch = 8'h2C;  7'd52: ch = 8'h2E;  7'd53: ch = 8'h2F;
      7'd55: ch = 8'h2A;  7'd57: ch = 8'h20;
      7'd82: ch = 8'h30;  7'd83: ch = 8'h7F;
      default: ch = CH_NP;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] upper_char(input logic [6:0] code);
    logic [7:0] ch;
    case (code)
      7'd0:  ch = 8'h00;  7'd1:  ch = 8'h1B;  7'd2:  ch = 8'h21;  7'd3:  ch = 8'h40;
      7'd4:  ch = 8'h23;  7'd5:  ch = 8'h24;  7'd6:  ch = 8'h25;  7'd7:  ch = 8'h5E;
      7'd8:  ch = 8'h26;  7'd9:  ch = 8'h2A;  7'd10: ch = 8'h28;  7'd11: ch = 8'h29;
      7'd12: ch = 8'h5F;  7'd13: ch = 8'h2B;  7'd14: ch = 8'h08;  7'd15: ch = 8'h09;
      7'd16: ch = 8'h51;  7'd17: ch = 8'h57;  7'd18: ch = 8'h45;  7'd19: ch = 8'h52;
      7'd20: ch = 8'h54;  7'd21: ch = 8'h59;  7'd22: ch = 8'h55;  7'd23: ch = 8'h49;
      7'd24: ch = 8'h4F;  7'd25: ch = 8'h50;  7'd26: ch = 8'h7B;  7'd27: ch = 8'h7D;
      7'd28: ch = 8'h0D;
      7'd30: ch = 8'h41;  7'd31: ch = 8'h53;  7'd32: ch = 8'h44;  7'd33: ch = 8'h46;
      7'd34: ch = 8'h47;  7'd35: ch = 8'h48;  7'd36: ch = 8'h4A;  7'd37: ch = 8'h4B;
      7'd38: ch = 8'h4C;  7'd39: ch = 8'h3A;  7'd40: ch = 8'h22;  7'd41: ch = 8'h7E;
      7'd43: ch = 8'h7C;  7'd44: ch = 8'h5A;  7'd45: ch = 8'h58;  7'd46: ch = 8'h43;
      7'd47: ch = 8'h56;  7'd48: ch = 8'h42;  7'd49: ch = 8'h4E;  7'd50: ch = 8'h4D;
      7'd51: ch = 8'h3C;  7'd52: ch = 8'h3E;  7'd53: ch = 8'h3F;
      7'd55: ch = 8'h2A;  7'd57: ch = 8'h20;
      7'd71: ch = 8'h37;  7'd72: ch = 8'h38;  7'd73: ch = 8'h39;
      7'd75: ch = 8'h34;  7'd76: ch = 8'h35;  7'd77: ch = 8'h36;
      7'd79: ch = 8'h31;  7'd80: ch = 8'h32;  7'd81: ch = 8'h33;
      7'd82: ch = 8'h30;  7'd83: ch = 8'h7F;
      default: ch = CH_NP;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] translate(input logic [6:0] code, input logic shift,
                                           input logic caps);
    logic [7:0] plain;
    logic       upper;
    logic [7:0] ch;
    plain = plain_char(code);
    upper = shift;
    if (caps && (plain >= CH_LOWER_A) && (plain <= CH_LOWER_Z)) begin
      upper = !shift;
    end
    if (code == 7'd0) begin
      ch = CH_NONE;
    end else if (code == SC_KP_STAR) begin
      ch = CH_STAR;
    end else if (upper) begin
      ch = upper_char(code);
    end else begin
      ch = plain;
    end
    return ch;
  endfunction

endpackage

// ----- hdl/kst_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_ctrl
// sequencer: accepts one transaction at a time and owns the output valid
// ----------------------------------------------------------------------------
module kst_ctrl
  import kst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        in_op_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  kst_status_t status_i,
  output kst_cmd_t    cmd_o
);

  kst_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        // output slot is free now or drains this cycle
        in_ready_o = !out_valid_q || out_ready_i;
        if (in_valid_i && in_ready_o) begin
          if (in_op_i == OP_SCAN) begin
            cmd_o.scan  = 1'b1;
            out_valid_d = 1'b1;
          end else if (status_i.empty) begin
            cmd_o.load_empty = 1'b1;
            out_valid_d      = 1'b1;
          end else begin
            cmd_o.pop = 1'b1;
            state_d   = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.load_read = 1'b1;
        out_valid_d     = 1'b1;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/kst_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_datapath
// modifier state, code store with pointers, translation and result register
// ----------------------------------------------------------------------------
module kst_datapath
  import kst_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [7:0]             scan_code_i,
  input  kst_cmd_t               cmd_i,
  output kst_status_t            status_o,
  output logic [OUT_TDATA_W-1:0] result_o
);

  localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  logic [6:0]    mem_q [FIFO_DEPTH];
  logic [6:0]    rd_data_q;

  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          shift_q, shift_d;
  logic          ctrl_q, ctrl_d;
  logic          caps_q, caps_d;
  // alt and num lock reach no output, so they are not kept

  logic          consumed;
  logic          push;
  logic          reboot;
  logic          full;
  logic [CW+LEVEL_W-1:0] level_ext;

  logic [7:0]         char_q, char_d;
  logic               empty_q, empty_d;
  logic               reboot_q, reboot_d;
  logic [LEVEL_W-1:0] level_q, level_d;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
    logic [PW-1:0] n;
    if (p == PW'(FIFO_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PW'(1);
    end
    return n;
  endfunction

  assign full = (count_q == CW'(FIFO_DEPTH));

  always_comb begin
    shift_d  = shift_q;
    ctrl_d   = ctrl_q;
    caps_d   = caps_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    consumed = 1'b1;
    push     = 1'b0;
    reboot   = 1'b0;
    if (cmd_i.scan) begin
      case (scan_code_i)
        SC_RSHIFT_MAKE, SC_LSHIFT_MAKE:   shift_d = 1'b1;
        SC_RSHIFT_BREAK, SC_LSHIFT_BREAK: shift_d = 1'b0;
        SC_CTRL_MAKE:                     ctrl_d  = 1'b1;
        SC_CTRL_BREAK:                    ctrl_d  = 1'b0;
        SC_ALT_MAKE, SC_ALT_BREAK:        consumed = 1'b1;
        SC_CAPS_MAKE, SC_NUM_MAKE, SC_EXTENDED, SC_NUM_BREAK: consumed = 1'b1;
        SC_CAPS_BREAK:                    caps_d  = !caps_q;
        default:                          consumed = 1'b0;
      endcase
      if (!consumed && !scan_code_i[7]) begin
        if (ctrl_q && (scan_code_i == SC_C_MAKE)) begin
          reboot = 1'b1;
        end else if (!full) begin
          push     = 1'b1;
          wr_ptr_d = advance(wr_ptr_q);
          count_d  = count_q + CW'(1);
        end else begin
          // overflow drops everything held
          wr_ptr_d = '0;
          rd_ptr_d = '0;
          count_d  = '0;
        end
      end
    end else if (cmd_i.pop) begin
      rd_ptr_d = advance(rd_ptr_q);
      count_d  = count_q - CW'(1);
    end
  end

  assign level_ext = {{LEVEL_W{1'b0}}, count_d};

  always_comb begin
    char_d   = char_q;
    empty_d  = empty_q;
    reboot_d = reboot_q;
    level_d  = level_q;
    if (cmd_i.scan || cmd_i.load_empty) begin
      char_d   = CH_NONE;
      empty_d  = cmd_i.load_empty;
      reboot_d = reboot;
      level_d  = level_ext[LEVEL_W-1:0];
    end else if (cmd_i.load_read) begin
      char_d   = translate(rd_data_q, shift_q, caps_q);
      empty_d  = 1'b0;
      reboot_d = 1'b0;
      level_d  = level_ext[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      shift_q  <= 1'b0;
      ctrl_q   <= 1'b0;
      caps_q   <= 1'b0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
      shift_q  <= shift_d;
      ctrl_q   <= ctrl_d;
      caps_q   <= caps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= scan_code_i[6:0];
    end
    if (cmd_i.pop) begin
      rd_data_q <= mem_q[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    char_q   <= char_d;
    empty_q  <= empty_d;
    reboot_q <= reboot_d;
    level_q  <= level_d;
  end

  assign status_o.empty = (count_q == '0);
  assign result_o       = {level_q, reboot_q, empty_q, char_q};

endmodule

// ----- hdl/keyboard_scancode_fifo_translator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_scancode_fifo_translator
// set-1 scan code queue with modifier tracking and ascii translation on read
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata                                  tuser
//  -------  ---  -------------------------------------  --------------------
//  s_axis   in   [7:0] scan_code                         [0] operation
//  m_axis   out  [7:0] char_out [8] was_empty            none
//                [9] reboot_request [15:10] fifo_level
//
// one transaction is in work at a time; a scan code or an empty read shows
// its result in the cycle after acceptance, a read that pops passes through
// ST_READ first, because the code store read data is registered before translation
// the next transaction is taken while a result waits, as soon as the output
// register drains
// reset clears pointers, count and modifiers; the store itself is not cleared
//
module keyboard_scancode_fifo_translator
  import kst_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] scan_code
  input  logic                   s_axis_tuser,   // [0] operation
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [7:0] char_out, [8] was_empty,
                                                 // [9] reboot_request,
                                                 // [15:10] fifo_level
);

  kst_cmd_t    cmd;
  kst_status_t status;

  // sequencer: handshakes and command issue
  kst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: store, modifiers, translation, result register
  kst_datapath #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scan_code_i (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (m_axis_tdata)
  );

endmodule

// ----- hdl/kst_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_checker
// port-level checks of the result stream, bound to the top level
// ----------------------------------------------------------------------------
module kst_checker
  import kst_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // an empty read carries no character and reports an empty store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[8]) |-> (m_axis_tdata[7:0] == CH_NONE) &&
                                           (m_axis_tdata[15:10] == '0))
  else $error("empty read with character or nonzero level");

  // a reboot request comes only from a scan code transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[9]) |-> !m_axis_tdata[8] &&
                                           (m_axis_tdata[7:0] == CH_NONE))
  else $error("reboot request mixed with read result");

  // a scan code result is valid in the cycle after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_SCAN)) |=> m_axis_tvalid)
  else $error("scan code result missing one cycle after acceptance");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
  else $error("stalled result changed");

endmodule

bind keyboard_scancode_fifo_translator kst_checker u_kst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// keystroke queue test: predicts every result of the scan code fifo and checks
// each output transaction field by field, under random idling on both streams
// ----------------------------------------------------------------------------
module testbench;
  import kst_pkg::*;

  localparam int unsigned DEPTH     = FIFO_DEPTH_DEFAULT;
  localparam int unsigned TBL_SIZE  = 84;
  localparam int unsigned TAIL_ITEMS = 150;

  // unshifted and shifted character tables, entry 0 in the leftmost byte
  localparam logic [0:TBL_SIZE-1][7:0] PLAIN_TBL = {
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, CH_NP,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
    8'h6C, 8'h3B, 8'h27, 8'h60, CH_NP,
    8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D,
    8'h2C, 8'h2E, 8'h2F, CH_NP,
    8'h2A, CH_NP, 8'h20, {9{CH_NP}},
    {12{CH_NP}},
    CH_NP, CH_NP, CH_NP, 8'h30, 8'h7F
  };

  localparam logic [0:TBL_SIZE-1][7:0] UPPER_TBL = {
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, CH_NP,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
    8'h4C, 8'h3A, 8'h22, 8'h7E, CH_NP,
    8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D,
    8'h3C, 8'h3E, 8'h3F, CH_NP,
    8'h2A, CH_NP, 8'h20, {9{CH_NP}},
    CH_NP, CH_NP, CH_NP, CH_NP, 8'h37, 8'h38, 8'h39, CH_NP,
    8'h34, 8'h35, 8'h36, CH_NP,
    8'h31, 8'h32, 8'h33, 8'h30, 8'h7F
  };

  typedef struct {
    logic        op;
    logic [7:0]  code;
    int unsigned gap;    // idle cycles before this item is offered
    bit          drain;  // hold until every result so far has arrived
  } key_item_t;

  typedef struct {
    logic [7:0] ch;
    logic       empty;
    logic       reboot;
    logic [5:0] level;
  } char_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = OP_SCAN;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  key_item_t    pending_keys[$];
  char_result_t expected_chars[$];
  int unsigned  mismatch_count = 0;
  int unsigned  result_index   = 0;

  // predictor state
  logic [6:0]  key_store [DEPTH];
  int unsigned key_wr, key_rd, key_count;
  bit          shift_down, ctrl_down, alt_down, caps_on, num_on;

  keyboard_scancode_fifo_translator i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [7:0] scan_code
    .s_axis_tuser (s_axis_tuser),   // [0] operation
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)    // [7:0] char_out, [8] was_empty,
                                    // [9] reboot_request, [15:10] fifo_level
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // character for a popped code, shift and caps taken at the time of the read
  function automatic logic [7:0] key_to_ascii(logic [6:0] code);
    logic [7:0] plain;
    bit         upper;
    if (code == 7'd0) return CH_NONE;
    if (code == SC_KP_STAR) return CH_STAR;
    if (code >= TBL_SIZE) return CH_NP;
    plain = PLAIN_TBL[code];
    upper = shift_down;
    // caps lock flips shift for letters only
    if (caps_on && plain >= CH_LOWER_A && plain <= CH_LOWER_Z) upper = !upper;
    return upper ? UPPER_TBL[code] : plain;
  endfunction

  // advances the predictor by one accepted transaction
  function automatic char_result_t translate_keystroke(logic op, logic [7:0] code);
    char_result_t r;
    bit           consumed;
    r = '{ch: CH_NONE, empty: 1'b0, reboot: 1'b0, level: '0};
    if (op == OP_SCAN) begin
      consumed = 1'b1;
      case (code)
        SC_RSHIFT_MAKE, SC_LSHIFT_MAKE:   shift_down = 1'b1;
        SC_RSHIFT_BREAK, SC_LSHIFT_BREAK: shift_down = 1'b0;
        SC_CTRL_MAKE:                     ctrl_down  = 1'b1;
        SC_CTRL_BREAK:                    ctrl_down  = 1'b0;
        SC_ALT_MAKE:                      alt_down   = 1'b1;
        SC_ALT_BREAK:                     alt_down   = 1'b0;
        SC_CAPS_MAKE, SC_NUM_MAKE, SC_EXTENDED: begin
        end
        SC_CAPS_BREAK:                    caps_on    = !caps_on;
        SC_NUM_BREAK:                     num_on     = !num_on;
        default:                          consumed   = 1'b0;
      endcase
      // other break codes fall through untouched
      if (!consumed && !code[7]) begin
        if (ctrl_down && code == SC_C_MAKE) begin
          r.reboot = 1'b1;
        end else if (key_count < DEPTH) begin
          key_store[key_wr] = code[6:0];
          key_wr = (key_wr + 1) % DEPTH;
          key_count++;
        end else begin
          // push into a full queue throws everything away
          key_wr    = 0;
          key_rd    = 0;
          key_count = 0;
        end
      end
    end else if (key_count == 0) begin
      r.empty = 1'b1;
    end else begin
      r.ch   = key_to_ascii(key_store[key_rd]);
      key_rd = (key_rd + 1) % DEPTH;
      key_count--;
    end
    r.level = key_count[5:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatch_count < 40) begin
      $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
               result_index, what, got, want);
    end
    mismatch_count++;
  endtask

  function automatic void add_item(logic op, logic [7:0] code);
    pending_keys.push_back('{op: op, code: code, gap: 0, drain: 1'b0});
  endfunction

  // make code that is stored rather than consumed as a modifier
  function automatic logic [7:0] pick_make_code();
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 8'h53))
                                     : 8'($urandom_range(0, 8'h7F));
    end while (c == SC_RSHIFT_MAKE || c == SC_LSHIFT_MAKE || c == SC_CTRL_MAKE ||
               c == SC_ALT_MAKE || c == SC_CAPS_MAKE || c == SC_NUM_MAKE);
    return c;
  endfunction

  function automatic logic [7:0] pick_modifier_code();
    case ($urandom_range(0, 12))
      0:       return SC_RSHIFT_MAKE;
      1:       return SC_LSHIFT_MAKE;
      2:       return SC_RSHIFT_BREAK;
      3:       return SC_LSHIFT_BREAK;
      4:       return SC_CTRL_MAKE;
      5:       return SC_CTRL_BREAK;
      6:       return SC_ALT_MAKE;
      7:       return SC_ALT_BREAK;
      8:       return SC_CAPS_MAKE;
      9:       return SC_NUM_MAKE;
      10:      return SC_EXTENDED;
      11:      return SC_CAPS_BREAK;
      default: return SC_NUM_BREAK;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers the head of pending_keys, predicts on every accepted
  // transaction
  // ---------------------------------------------------------------------------
  bit          key_fire;
  bit          gap_armed;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= OP_SCAN;
      gap_armed = 1'b0;
      gap_left  = 0;
    end else begin
      key_fire = s_axis_tvalid && s_axis_tready;
      if (key_fire) begin
        expected_chars.push_back(translate_keystroke(s_axis_tuser, s_axis_tdata));
        void'(pending_keys.pop_front());
        gap_armed = 1'b0;
      end
      if (!s_axis_tvalid || key_fire) begin
        if (pending_keys.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          if (!gap_armed) begin
            gap_left  = pending_keys[0].gap;
            gap_armed = 1'b1;
          end
          if (gap_left > 0) begin
            gap_left--;
            s_axis_tvalid <= 1'b0;
          end else if (pending_keys[0].drain && expected_chars.size() != 0) begin
            // sender holds off until the block has handed back everything
            s_axis_tvalid <= 1'b0;
          end else begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= pending_keys[0].code;
            s_axis_tuser  <= pending_keys[0].op;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random stall bursts on the result stream, checks each accepted
  // transaction against the oldest prediction
  // ---------------------------------------------------------------------------
  char_result_t want;
  int unsigned  stall_left;
  int unsigned  mode_left;
  bit           ready_calm;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
      mode_left  = 0;
      ready_calm = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("result with nothing pending, tdata", m_axis_tdata, 0);
        end else begin
          want = expected_chars.pop_front();
          if (m_axis_tdata[7:0] !== want.ch)
            report_mismatch("char_out", m_axis_tdata[7:0], want.ch);
          if (m_axis_tdata[8] !== want.empty)
            report_mismatch("was_empty", m_axis_tdata[8], want.empty);
          if (m_axis_tdata[9] !== want.reboot)
            report_mismatch("reboot_request", m_axis_tdata[9], want.reboot);
          if (m_axis_tdata[15:10] !== want.level)
            report_mismatch("fifo_level", m_axis_tdata[15:10], want.level);
        end
        result_index++;
      end
      // alternate between calm and busy stretches
      if (mode_left == 0) begin
        mode_left  = $urandom_range(50, 300);
        ready_calm = ($urandom_range(0, 2) == 0);
      end else begin
        mode_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!ready_calm && pending_keys.size() >= TAIL_ITEMS &&
                   $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned kind, n, j, first_random;
    bit          calm;

    // empty read, code zero, high make code, keypad star, last table entry
    add_item(OP_READ, 8'hFF);
    add_item(OP_SCAN, 8'h00);
    add_item(OP_SCAN, 8'h7F);
    add_item(OP_SCAN, 8'h48);
    add_item(OP_SCAN, 8'h53);
    add_item(OP_SCAN, 8'h1E);
    add_item(OP_SCAN, 8'h02);
    add_item(OP_SCAN, SC_LSHIFT_MAKE);
    for (j = 0; j < 6; j++) add_item(OP_READ, 8'($urandom_range(0, 255)));
    // caps lock with and without shift
    add_item(OP_SCAN, SC_LSHIFT_BREAK);
    add_item(OP_SCAN, SC_CAPS_BREAK);
    add_item(OP_SCAN, 8'h1E);
    add_item(OP_SCAN, SC_RSHIFT_MAKE);
    add_item(OP_READ, 8'h00);
    add_item(OP_SCAN, SC_RSHIFT_BREAK);
    // ctrl-c, consumed codes and a dropped break
    add_item(OP_SCAN, SC_CTRL_MAKE);
    add_item(OP_SCAN, SC_C_MAKE);
    add_item(OP_SCAN, SC_CTRL_BREAK);
    add_item(OP_SCAN, SC_EXTENDED);
    add_item(OP_SCAN, SC_NUM_BREAK);
    add_item(OP_SCAN, 8'hFF);

    first_random = pending_keys.size();
    while (pending_keys.size() < 1330) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        // typing burst, then read it back
        n = $urandom_range(1, 10);
        for (j = 0; j < n; j++) begin
          if ($urandom_range(0, 5) == 0) add_item(OP_SCAN, pick_modifier_code());
          add_item(OP_SCAN, pick_make_code());
        end
        n += $urandom_range(0, 2);
        for (j = 0; j < n; j++) begin
          if ($urandom_range(0, 7) == 0) add_item(OP_SCAN, pick_modifier_code());
          add_item(OP_READ, 8'($urandom_range(0, 255)));
        end
      end else if (kind < 55) begin
        // run the queue past full
        add_item(OP_SCAN, SC_CTRL_BREAK);
        for (j = 0; j < 34; j++) add_item(OP_SCAN, pick_make_code());
        n = $urandom_range(0, 34);
        for (j = 0; j < n; j++) add_item(OP_READ, 8'($urandom_range(0, 255)));
      end else if (kind < 65) begin
        add_item(OP_SCAN, SC_CTRL_MAKE);
        n = $urandom_range(0, 3);
        for (j = 0; j < n; j++) add_item(OP_SCAN, pick_make_code());
        add_item(OP_SCAN, SC_C_MAKE);
        add_item(OP_SCAN, SC_CTRL_BREAK);
      end else if (kind < 75) begin
        n = $urandom_range(1, 4);
        for (j = 0; j < n; j++) add_item(OP_SCAN, pick_modifier_code());
      end else if (kind < 85) begin
        n = $urandom_range(1, 12);
        for (j = 0; j < n; j++) add_item(OP_READ, 8'($urandom_range(0, 255)));
      end else begin
        // noise
        n = $urandom_range(1, 6);
        for (j = 0; j < n; j++)
          add_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end

    // idle bursts in random stretches, none over the last items
    calm = 1'b0;
    for (j = 0; j + TAIL_ITEMS < pending_keys.size(); j++) begin
      if ($urandom_range(0, 99) == 0) calm = !calm;
      if (!calm && $urandom_range(0, 5) == 0) pending_keys[j].gap = $urandom_range(1, 15);
      if (j > first_random && $urandom_range(0, 199) == 0) pending_keys[j].drain = 1'b1;
    end
    pending_keys[first_random].drain = 1'b1;

    key_wr     = 0;
    key_rd     = 0;
    key_count  = 0;
    shift_down = 1'b0;
    ctrl_down  = 1'b0;
    alt_down   = 1'b0;
    caps_on    = 1'b0;
    num_on     = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_keys.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5ms;
    $display("timeout waiting for results");
    $display("FAILED: results differ");
    $finish;
  end

endmodule
